// ----- design/arpc_pkg.sv -----
package arpc_pkg;

    localparam int CacheDepthDef   = 64;
    localparam int PendingDepthDef = 16;

    localparam logic [2:0] REQ_RX     = 3'd0;
    localparam logic [2:0] REQ_SEND   = 3'd1;
    localparam logic [2:0] REQ_LOOKUP = 3'd2;
    localparam logic [2:0] REQ_REMOVE = 3'd3;
    localparam logic [2:0] REQ_TICK   = 3'd4;

    localparam logic [15:0] OPER_REQUEST = 16'd1;
    localparam logic [15:0] OPER_REPLY   = 16'd2;

    localparam logic [1:0] TX_NONE  = 2'd0;
    localparam logic [1:0] TX_REPLY = 2'd1;
    localparam logic [1:0] TX_BCAST = 2'd2;

    localparam logic [1:0] CFG_LOCAL_MAC  = 2'd0;
    localparam logic [1:0] CFG_LOCAL_ADDR = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT    = 2'd2;

    localparam logic [1:0] CACHE_OP_INS = 2'd0;
    localparam logic [1:0] CACHE_OP_LKP = 2'd1;
    localparam logic [1:0] CACHE_OP_REM = 2'd2;

    localparam logic [47:0] MAC_BCAST = {6{8'hFF}};

    typedef struct packed {
        logic [2:0]  req_type;
        logic [15:0] oper;
        logic [15:0] ptype;
        logic [47:0] sender_mac;
        logic [31:0] sender_addr;
        logic [31:0] target_addr;
    } arpc_in_t;

    typedef struct packed {
        logic [1:0]  tx_kind;
        logic [47:0] tx_dest_mac;
        logic [47:0] tx_target_mac;
        logic [31:0] tx_target_addr;
        logic [15:0] tx_ptype;
        logic        lookup_hit;
        logic [47:0] lookup_mac;
        logic        cache_full;
        logic        pending_full;
    } arpc_out_t;

endpackage

// ----- design/arpc_cache.sv -----
module arpc_cache #(
    parameter int CACHE_DEPTH = arpc_pkg::CacheDepthDef
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [1:0]  op,
    input  logic [47:0] key,
    input  logic [47:0] hw,
    output logic        done,
    output logic        hit,
    output logic [47:0] hit_hw,
    output logic        full
);
    import arpc_pkg::*;

    localparam int AW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
    localparam logic [AW:0] LAST = (AW+1)'(CACHE_DEPTH - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_CHK  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [47:0] key_mem [CACHE_DEPTH];
    logic [47:0] hw_mem  [CACHE_DEPTH];
    logic [CACHE_DEPTH-1:0] valid_reg, valid_next;

    logic [1:0]    state_reg, state_next;
    logic [AW-1:0] idx_reg, idx_next, prv_reg;
    logic          hit_reg, hit_next, free_reg, free_next;
    logic [AW-1:0] hidx_reg, hidx_next, fidx_reg, fidx_next;
    logic [47:0]   rd_key, rd_hw;
    logic          prv_valid;
    logic          wr_en;

    always_ff @(posedge aclk) begin
        rd_key <= key_mem[idx_reg];
        rd_hw  <= hw_mem[hidx_next];
        if (wr_en) begin
            key_mem[fidx_reg] <= key;
            hw_mem[fidx_reg]  <= hw;
        end
    end

    assign prv_valid = valid_reg[prv_reg];

    always_comb begin
        state_next = state_reg;
        idx_next = idx_reg;
        hit_next = hit_reg;
        hidx_next = hidx_reg;
        free_next = free_reg;
        fidx_next = fidx_reg;
        valid_next = valid_reg;
        wr_en = 1'b0;
        done = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    state_next = S_SCAN;
                    idx_next = '0;
                    hit_next = 1'b0;
                    free_next = 1'b0;
                end
            end
            S_SCAN, S_CHK: begin
                if (state_reg == S_CHK) begin
                    if (prv_valid && rd_key == key && !hit_reg) begin
                        hit_next = 1'b1;
                        hidx_next = prv_reg;
                    end
                    if (!prv_valid && !free_reg) begin
                        free_next = 1'b1;
                        fidx_next = prv_reg;
                    end
                end
                if (state_reg == S_CHK && {1'b0, prv_reg} == LAST) begin
                    state_next = S_FIN;
                end else begin
                    state_next = S_CHK;
                    if ({1'b0, idx_reg} != LAST) idx_next = idx_reg + 1'b1;
                end
            end
            S_FIN: begin
                done = 1'b1;
                state_next = S_IDLE;
                if (op == CACHE_OP_INS && !hit_reg && free_reg) begin
                    wr_en = 1'b1;
                    valid_next[fidx_reg] = 1'b1;
                end
                if (op == CACHE_OP_REM && hit_reg) valid_next[hidx_reg] = 1'b0;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign hit    = hit_reg;
    assign hit_hw = rd_hw;
    assign full   = (op == CACHE_OP_INS) && !hit_reg && !free_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
        idx_reg  <= idx_next;
        prv_reg  <= idx_reg;
        hit_reg  <= hit_next;
        hidx_reg <= hidx_next;
        free_reg <= free_next;
        fidx_reg <= fidx_next;
    end
endmodule

// ----- design/arpc_pend.sv -----
module arpc_pend #(
    parameter int PENDING_DEPTH = arpc_pkg::PendingDepthDef
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic        is_send,
    input  logic [47:0] key,
    input  logic [31:0] now,
    input  logic [31:0] timeout,
    output logic        done,
    output logic        live,
    output logic        full
);
    localparam int PW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam logic [PW:0] LAST = (PW+1)'(PENDING_DEPTH - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [47:0] key_reg  [PENDING_DEPTH];
    logic [31:0] time_reg [PENDING_DEPTH];
    logic [PENDING_DEPTH-1:0] valid_reg, valid_next;

    logic [1:0]    state_reg, state_next;
    logic [PW-1:0] idx_reg, idx_next, fidx_reg, fidx_next;
    logic          live_reg, live_next, free_reg, free_next;
    logic [31:0]   age;
    logic          wr_en;

    assign age = now - time_reg[idx_reg];

    always_comb begin
        state_next = state_reg;
        idx_next = idx_reg;
        live_next = live_reg;
        free_next = free_reg;
        fidx_next = fidx_reg;
        valid_next = valid_reg;
        wr_en = 1'b0;
        done = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    state_next = S_SCAN;
                    idx_next = '0;
                    live_next = 1'b0;
                    free_next = 1'b0;
                end
            end
            S_SCAN: begin
                if (valid_reg[idx_reg]) begin
                    if (is_send && age > timeout) begin
                        valid_next[idx_reg] = 1'b0;
                    end else if (key_reg[idx_reg] == key) begin
                        if (is_send) live_next = 1'b1;
                        else valid_next[idx_reg] = 1'b0;
                    end
                end
                if (!valid_next[idx_reg] && !free_reg) begin
                    free_next = 1'b1;
                    fidx_next = idx_reg;
                end
                if ({1'b0, idx_reg} == LAST) state_next = S_FIN;
                else idx_next = idx_reg + 1'b1;
            end
            S_FIN: begin
                done = 1'b1;
                state_next = S_IDLE;
                if (is_send && !live_reg && free_reg) begin
                    wr_en = 1'b1;
                    valid_next[fidx_reg] = 1'b1;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign live = live_reg;
    assign full = is_send && !live_reg && !free_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_reg[fidx_reg]  <= key;
            time_reg[fidx_reg] <= now;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
        idx_reg  <= idx_next;
        live_reg <= live_next;
        free_reg <= free_next;
        fidx_reg <= fidx_next;
    end
endmodule

// ----- design/arp_cache_and_responder.sv -----
// ARP cache and responder. Each item is taken, processed and answered with
// exactly one result; s_ready is low from acceptance until the result is
// taken. A received packet with a request or reply opcode scans the cache
// (one entry per cycle through the key memory read port) and then the
// pending table; send items scan the pending table only, lookup and remove
// items the cache only; tick and all other items scan neither table.
// Configuration is written through cfg_* at any time while idle; the
// timeout register tmo_reg resets to 1000.
module arp_cache_and_responder #(
    parameter int CACHE_DEPTH   = arpc_pkg::CacheDepthDef,
    parameter int PENDING_DEPTH = arpc_pkg::PendingDepthDef
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  arpc_pkg::arpc_in_t s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output arpc_pkg::arpc_out_t m_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [47:0]        cfg_data
);
    import arpc_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CACHE = 3'd1;
    localparam logic [2:0] S_PSTART = 3'd2;
    localparam logic [2:0] S_PEND = 3'd3;
    localparam logic [2:0] S_OUT = 3'd4;
    localparam logic [2:0] S_CWAIT = 3'd5;

    logic [2:0]  state_reg, state_next;
    arpc_in_t    in_reg;
    arpc_out_t   out_reg, out_next;
    logic [47:0] mac_reg;
    logic [31:0] addr_reg, tmo_reg, now_reg;

    logic        c_start, c_done, c_hit, c_full;
    logic [1:0]  c_op;
    logic [47:0] c_key, c_hw;
    logic        p_start, p_done, p_live, p_full, p_send;
    logic [47:0] p_key;
    logic        is_rx_valid;

    assign is_rx_valid = in_reg.req_type == REQ_RX &&
        (in_reg.oper == OPER_REQUEST || in_reg.oper == OPER_REPLY);
    assign c_op = (in_reg.req_type == REQ_LOOKUP) ? CACHE_OP_LKP :
                  (in_reg.req_type == REQ_REMOVE) ? CACHE_OP_REM : CACHE_OP_INS;
    assign c_key = (in_reg.req_type == REQ_RX) ? {in_reg.ptype, in_reg.sender_addr}
                                               : {in_reg.ptype, in_reg.target_addr};
    assign p_send = in_reg.req_type == REQ_SEND;
    assign p_key = c_key;

    arpc_cache #(.CACHE_DEPTH(CACHE_DEPTH)) u_cache (
        .aclk, .aresetn, .start(c_start), .op(c_op), .key(c_key),
        .hw(in_reg.sender_mac), .done(c_done), .hit(c_hit), .hit_hw(c_hw),
        .full(c_full)
    );

    arpc_pend #(.PENDING_DEPTH(PENDING_DEPTH)) u_pend (
        .aclk, .aresetn, .start(p_start), .is_send(p_send), .key(p_key),
        .now(now_reg), .timeout(tmo_reg), .done(p_done), .live(p_live),
        .full(p_full)
    );

    assign s_ready   = state_reg == S_IDLE;
    assign cfg_ready = state_reg == S_IDLE;
    assign m_valid   = state_reg == S_OUT;
    assign m_data    = out_reg;

    always_comb begin
        state_next = state_reg;
        out_next = out_reg;
        c_start = 1'b0;
        p_start = 1'b0;
        unique case (state_reg)
            S_IDLE: if (s_valid) state_next = S_CWAIT;
            S_CWAIT: begin
                out_next = '0;
                if (in_reg.req_type == REQ_RX && in_reg.oper == OPER_REQUEST &&
                    in_reg.target_addr == addr_reg) begin
                    out_next.tx_kind = TX_REPLY;
                    out_next.tx_dest_mac = in_reg.sender_mac;
                    out_next.tx_target_mac = in_reg.sender_mac;
                    out_next.tx_target_addr = in_reg.sender_addr;
                    out_next.tx_ptype = in_reg.ptype;
                end
                if (is_rx_valid || in_reg.req_type == REQ_LOOKUP ||
                    in_reg.req_type == REQ_REMOVE) begin
                    c_start = 1'b1;
                    state_next = S_CACHE;
                end else if (p_send) begin
                    state_next = S_PSTART;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_CACHE: if (c_done) begin
                if (in_reg.req_type == REQ_LOOKUP && c_hit) begin
                    out_next.lookup_hit = 1'b1;
                    out_next.lookup_mac = c_hw;
                end
                out_next.cache_full = is_rx_valid && c_full;
                state_next = is_rx_valid ? S_PSTART : S_OUT;
            end
            S_PSTART: begin
                p_start = 1'b1;
                state_next = S_PEND;
            end
            S_PEND: if (p_done) begin
                if (p_send && !p_live) begin
                    out_next.tx_kind = TX_BCAST;
                    out_next.tx_dest_mac = MAC_BCAST;
                    out_next.tx_target_mac = '0;
                    out_next.tx_target_addr = in_reg.target_addr;
                    out_next.tx_ptype = in_reg.ptype;
                    out_next.pending_full = p_full;
                end
                state_next = S_OUT;
            end
            S_OUT: if (m_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mac_reg <= '0;
            addr_reg <= '0;
            tmo_reg <= 32'd1000;
            now_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_LOCAL_MAC:  mac_reg <= cfg_data;
                    CFG_LOCAL_ADDR: addr_reg <= cfg_data[31:0];
                    CFG_TIMEOUT:    tmo_reg <= cfg_data[31:0];
                    default: ;
                endcase
            end
            if (state_reg == S_CWAIT && in_reg.req_type == REQ_TICK)
                now_reg <= now_reg + 32'd1;
        end
        if (s_valid && s_ready) in_reg <= s_data;
        out_reg <= out_next;
    end

    logic unused_mac;
    assign unused_mac = ^mac_reg;
endmodule

// ----- bench/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import arpc_pkg::*;

    localparam int NCACHE = 64;
    localparam int NPEND  = 16;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE = 200;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    arpc_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    arpc_out_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [47:0] cfg_data = '0;

    arp_cache_and_responder dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // model state
    logic [47:0] my_mac;
    logic [31:0] my_addr;
    logic [31:0] pend_timeout;
    bit          arp_valid [NCACHE];
    logic [47:0] arp_key [NCACHE];
    logic [47:0] arp_hw [NCACHE];
    bit          req_valid [NPEND];
    logic [47:0] req_key [NPEND];
    logic [31:0] req_time [NPEND];
    logic [31:0] tick_now;

    arpc_in_t  pending_items[$];
    arpc_out_t expected_replies[$];
    int fail_count = 0;
    int idle_cycles = 0;
    int burst_left = 0;
    int gap_left = 0;
    int stall_phase = 0;
    bit feeding = 1'b0;

    task automatic report_mismatch(input string what);
        $display("mismatch: %s", what);
        fail_count++;
    endtask

    function automatic int find_mapping(input logic [47:0] key);
        for (int i = 0; i < NCACHE; i++)
            if (arp_valid[i] && arp_key[i] == key) return i;
        return -1;
    endfunction

    function automatic arpc_out_t predict_arp(input arpc_in_t it);
        arpc_out_t r;
        logic [47:0] key;
        int slot;
        bit live;
        r = '0;
        case (it.req_type)
            REQ_RX: begin
                if (it.oper == OPER_REQUEST && it.target_addr == my_addr) begin
                    r.tx_kind = TX_REPLY;
                    r.tx_dest_mac = it.sender_mac;
                    r.tx_target_mac = it.sender_mac;
                    r.tx_target_addr = it.sender_addr;
                    r.tx_ptype = it.ptype;
                end
                if (it.oper == OPER_REQUEST || it.oper == OPER_REPLY) begin
                    key = {it.ptype, it.sender_addr};
                    if (find_mapping(key) < 0) begin
                        slot = -1;
                        for (int i = 0; i < NCACHE; i++)
                            if (!arp_valid[i] && slot < 0) slot = i;
                        if (slot < 0) r.cache_full = 1'b1;
                        else begin
                            arp_valid[slot] = 1'b1;
                            arp_key[slot] = key;
                            arp_hw[slot] = it.sender_mac;
                        end
                    end
                    for (int i = 0; i < NPEND; i++)
                        if (req_valid[i] && req_key[i] == key) req_valid[i] = 1'b0;
                end
            end
            REQ_SEND: begin
                key = {it.ptype, it.target_addr};
                live = 1'b0;
                for (int i = 0; i < NPEND; i++) begin
                    if (req_valid[i]) begin
                        if (32'(tick_now - req_time[i]) > pend_timeout)
                            req_valid[i] = 1'b0;
                        else if (req_key[i] == key) live = 1'b1;
                    end
                end
                if (!live) begin
                    r.tx_kind = TX_BCAST;
                    r.tx_dest_mac = MAC_BCAST;
                    r.tx_target_addr = it.target_addr;
                    r.tx_ptype = it.ptype;
                    slot = -1;
                    for (int i = 0; i < NPEND; i++)
                        if (!req_valid[i] && slot < 0) slot = i;
                    if (slot < 0) r.pending_full = 1'b1;
                    else begin
                        req_valid[slot] = 1'b1;
                        req_key[slot] = key;
                        req_time[slot] = tick_now;
                    end
                end
            end
            REQ_LOOKUP: begin
                slot = find_mapping({it.ptype, it.target_addr});
                if (slot >= 0) begin
                    r.lookup_hit = 1'b1;
                    r.lookup_mac = arp_hw[slot];
                end
            end
            REQ_REMOVE: begin
                slot = find_mapping({it.ptype, it.target_addr});
                if (slot >= 0) arp_valid[slot] = 1'b0;
            end
            REQ_TICK: tick_now = tick_now + 32'd1;
            default: ;
        endcase
        return r;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_replies.push_back(predict_arp(s_data));
            end
            if (!s_valid || s_ready) begin
                if (pending_items.size() > 0 && feeding && burst_left > 0) begin
                    s_data <= pending_items.pop_front();
                    s_valid <= 1'b1;
                    burst_left <= burst_left - 1;
                end else begin
                    s_valid <= 1'b0;
                    if (gap_left > 0) gap_left <= gap_left - 1;
                    else begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 40);
                    end
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        arpc_out_t e;
        if (aresetn) begin
            stall_phase <= (stall_phase + 1) % 37;
            m_ready <= (stall_phase < 20) ? 1'b1 : ($urandom_range(0, 2) == 0);
            if (m_valid && m_ready) begin
                idle_cycles <= 0;
                if (expected_replies.size() == 0)
                    report_mismatch("result with nothing expected");
                else begin
                    e = expected_replies.pop_front();
                    if (m_data.tx_kind !== e.tx_kind) report_mismatch("tx_kind");
                    if (m_data.tx_dest_mac !== e.tx_dest_mac) report_mismatch("tx_dest_mac");
                    if (m_data.tx_target_mac !== e.tx_target_mac)
                        report_mismatch("tx_target_mac");
                    if (m_data.tx_target_addr !== e.tx_target_addr)
                        report_mismatch("tx_target_addr");
                    if (m_data.tx_ptype !== e.tx_ptype) report_mismatch("tx_ptype");
                    if (m_data.lookup_hit !== e.lookup_hit) report_mismatch("lookup_hit");
                    if (m_data.lookup_mac !== e.lookup_mac) report_mismatch("lookup_mac");
                    if (m_data.cache_full !== e.cache_full) report_mismatch("cache_full");
                    if (m_data.pending_full !== e.pending_full)
                        report_mismatch("pending_full");
                end
            end else if (s_valid && s_ready) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("== FAIL ==");
                    $finish;
                end
            end
        end
    end

    // small address pools so that hits, duplicates and full tables occur
    logic [15:0] ptype_pool [4] = '{16'h0800, 16'h86DD, 16'h0000, 16'hFFFF};

    function automatic logic [31:0] pick_addr(input int spread);
        if ($urandom_range(0, 9) == 0) return $urandom();
        return 32'h0A00_0000 + $urandom_range(0, spread);
    endfunction

    function automatic arpc_in_t make_item(input int spread);
        arpc_in_t it;
        int pick;
        it = '0;
        it.ptype = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : ptype_pool[$urandom_range(0, 3)];
        it.target_addr = pick_addr(spread);
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            it.req_type = REQ_RX;
            it.oper = ($urandom_range(0, 9) == 0) ? 16'($urandom()) :
                      (($urandom_range(0, 1) == 1) ? OPER_REQUEST : OPER_REPLY);
            it.sender_mac = 48'({$urandom(), $urandom()});
            it.sender_addr = pick_addr(spread);
            if ($urandom_range(0, 3) == 0) it.target_addr = my_addr;
        end else if (pick < 60) it.req_type = REQ_SEND;
        else if (pick < 72) it.req_type = REQ_LOOKUP;
        else if (pick < 80) it.req_type = REQ_REMOVE;
        else if (pick < 97) it.req_type = REQ_TICK;
        else it.req_type = 3'($urandom_range(5, 7));
        return it;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [47:0] val);
        @(posedge aclk);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_LOCAL_MAC:  my_mac = val;
            CFG_LOCAL_ADDR: my_addr = val[31:0];
            CFG_TIMEOUT:    pend_timeout = val[31:0];
            default: ;
        endcase
    endtask

    task automatic drain_all();
        feeding = 1'b1;
        while (pending_items.size() > 0 || expected_replies.size() > 0 || s_valid)
            @(posedge aclk);
        feeding = 1'b0;
        repeat (SETTLE) @(posedge aclk);
    endtask

    initial begin
        arpc_in_t it;
        logic [31:0] tmo [4];
        tmo = '{32'd1, 32'd5, 32'hFFFF_FFFF, 32'd40};
        my_mac = '0;
        my_addr = '0;
        pend_timeout = 32'd1000;
        tick_now = '0;
        foreach (arp_valid[i]) arp_valid[i] = 1'b0;
        foreach (req_valid[i]) req_valid[i] = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset-value target, extremes, every type
        it = '0; it.req_type = REQ_RX; it.oper = OPER_REQUEST;
        it.sender_mac = '1; it.sender_addr = '1; it.ptype = '1;
        pending_items.push_back(it);
        it.req_type = REQ_LOOKUP; it.target_addr = '1; pending_items.push_back(it);
        it = '0; it.req_type = REQ_RX; it.oper = OPER_REPLY; it.sender_mac = 48'h1;
        pending_items.push_back(it);
        it.sender_mac = 48'h2; pending_items.push_back(it);
        it.req_type = REQ_LOOKUP; pending_items.push_back(it);
        it = '0; it.req_type = REQ_RX; it.oper = 16'hFFFF; it.sender_addr = 32'h5;
        pending_items.push_back(it);
        it = '0; it.req_type = REQ_SEND; it.target_addr = 32'h7; pending_items.push_back(it);
        pending_items.push_back(it);
        it.req_type = REQ_RX; it.oper = OPER_REPLY; it.sender_addr = 32'h7;
        pending_items.push_back(it);
        it = '0; it.req_type = REQ_SEND; it.target_addr = 32'h7; pending_items.push_back(it);
        it.req_type = REQ_REMOVE; it.target_addr = '0; pending_items.push_back(it);
        it.req_type = REQ_LOOKUP; pending_items.push_back(it);
        it.req_type = REQ_TICK; pending_items.push_back(it);
        for (int t = 5; t <= 7; t++) begin
            it = '1; it.req_type = 3'(t); pending_items.push_back(it);
        end
        for (int k = 0; k < 17; k++) begin
            it = '0; it.req_type = REQ_SEND; it.target_addr = 32'h100 + k;
            pending_items.push_back(it);
        end
        drain_all();

        // random phases across register settings
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(CFG_LOCAL_MAC, (ph == 1) ? 48'hFFFF_FFFF_FFFF :
                      48'({$urandom(), $urandom()}));
            write_reg(CFG_LOCAL_ADDR, 48'((ph == 2) ? 32'hFFFF_FFFF :
                      32'h0A00_0000 + $urandom_range(0, 80)));
            write_reg(CFG_TIMEOUT, 48'(tmo[ph % 4]));
            for (int n = 0; n < 200; n++)
                pending_items.push_back(make_item((ph % 2 == 0) ? 20 : 120));
            drain_all();
        end

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

// ----- arp_cache_and_responder.f -----
design/arpc_pkg.sv
design/arpc_cache.sv
design/arpc_pend.sv
design/arp_cache_and_responder.sv
bench/testbench.sv
